### sv/em3_pkg.sv
package em3_pkg;

  localparam int ALPHA = 26;
  localparam int NROTOR = 5;
  localparam int NSTAGE = 7;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 15;

  // exact reciprocals for 15-bit / 676 and 10-bit / 26
  localparam int RECIP_676 = 24819;
  localparam int RECIP_676_SH = 24;
  localparam int RECIP_26 = 2521;
  localparam int RECIP_26_SH = 16;

  typedef logic [4:0] em3_letter_t;
  typedef logic [2:0] em3_sel_t;
  typedef logic [2:0][4:0] em3_triple_t;
  typedef logic [2:0][2:0] em3_rotsel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROTOR_LEFT   = 3'd0,
    REG_ROTOR_MIDDLE = 3'd1,
    REG_ROTOR_RIGHT  = 3'd2,
    REG_RING         = 3'd3,
    REG_START        = 3'd4
  } em3_reg_t;

  typedef struct packed {
    em3_rotsel_t rot;
    em3_triple_t ring;
    em3_triple_t start;
    logic        busy;
  } em3_cfg_t;

  typedef struct packed {
    em3_letter_t letter;
    logic        bad;
    em3_rotsel_t rot;
    em3_triple_t shift;
  } em3_job_t;

  localparam logic [ALPHA*8-1:0] WIRING [NROTOR] = '{
    "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
    "AJDKSIRUXBLHWTMCQGZNPYFVOE",
    "BDFHJLCPRTXVZNYEIWGAKMUSQO",
    "ESOVPZJAYQUIRHXLNFTGKDCMWB",
    "VZBRGITYUPSDNHLXAWMJQOFECK"
  };
  localparam logic [ALPHA*8-1:0] REFLECTOR_B = "YRUHQSLDPXNGOKMIEBFZCWVJAT";
  localparam em3_letter_t NOTCH [NROTOR] = '{5'd16, 5'd4, 5'd21, 5'd9, 5'd25};
  localparam em3_letter_t LAST_LETTER = 5'(ALPHA - 1);
  localparam em3_sel_t LAST_ROTOR = 3'(NROTOR - 1);

  function automatic em3_letter_t code_of(logic [7:0] ch);
    return ch[4:0] - 5'd1;
  endfunction

  function automatic em3_letter_t add_mod(em3_letter_t a, em3_letter_t b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 6'(ALPHA)) begin
      s = s - 6'(ALPHA);
    end
    return s[4:0];
  endfunction

  function automatic em3_letter_t sub_mod(em3_letter_t a, em3_letter_t b);
    logic [5:0] d;
    if (a >= b) begin
      d = {1'b0, a} - {1'b0, b};
    end else begin
      d = {1'b0, a} + 6'(ALPHA) - {1'b0, b};
    end
    return d[4:0];
  endfunction

  function automatic em3_sel_t clamp_rotor(em3_sel_t sel);
    return (sel > LAST_ROTOR) ? LAST_ROTOR : sel;
  endfunction

  function automatic em3_letter_t wire_fwd(em3_sel_t rot, em3_letter_t x);
    em3_letter_t r;
    r = '0;
    for (int i = 0; i < ALPHA; i++) begin
      if (x == 5'(i)) begin
        r = code_of(WIRING[rot][8*(ALPHA-1-i) +: 8]);
      end
    end
    return r;
  endfunction

  function automatic em3_letter_t wire_back(em3_sel_t rot, em3_letter_t x);
    em3_letter_t r;
    r = '0;
    for (int i = 0; i < ALPHA; i++) begin
      if (code_of(WIRING[rot][8*(ALPHA-1-i) +: 8]) == x) begin
        r = 5'(i);
      end
    end
    return r;
  endfunction

  function automatic em3_letter_t reflect(em3_letter_t x);
    em3_letter_t r;
    r = '0;
    for (int i = 0; i < ALPHA; i++) begin
      if (x == 5'(i)) begin
        r = code_of(REFLECTOR_B[8*(ALPHA-1-i) +: 8]);
      end
    end
    return r;
  endfunction

endpackage

### sv/em3_if.sv
interface em3_in_if import em3_pkg::*; ();
  logic        valid;
  logic        ready;
  em3_letter_t letter_in;
  logic        message_start;

  modport source (output valid, letter_in, message_start, input ready);
  modport sink (input valid, letter_in, message_start, output ready);
endinterface

interface em3_out_if import em3_pkg::*; ();
  logic        valid;
  logic        ready;
  em3_letter_t letter_out;
  logic        bad_letter;

  modport source (output valid, letter_out, bad_letter, input ready);
  modport sink (input valid, letter_out, bad_letter, output ready);
endinterface

interface em3_cfg_if import em3_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/em3_cfg.sv
module em3_cfg import em3_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  em3_cfg_if.sink   cfg,
  output em3_cfg_t  conf
);

  em3_rotsel_t           rot_r;
  em3_triple_t           ring_r;
  em3_triple_t           start_r;

  logic                  p0_vld_r, p1_vld_r, p2_vld_r, p3_vld_r;
  logic                  p0_tag_r, p1_tag_r, p2_tag_r, p3_tag_r;
  logic [CFG_DATA_W-1:0] p0_v_r, p1_v_r;
  logic [5:0]            p1_q_r;
  em3_letter_t           p2_left_r, p3_left_r;
  logic [9:0]            p2_rem_r, p3_rem_r;
  em3_letter_t           p3_mid_r;

  logic                  wr;
  logic [29:0]           q_prod;
  logic [5:0]            q_left;
  logic [CFG_DATA_W-1:0] q_back;
  logic [CFG_DATA_W-1:0] rem_full;
  logic [21:0]           m_prod;
  logic [9:0]            m_back;
  logic [9:0]            right_full;

  assign cfg.ready = 1'b1;
  assign wr = cfg.valid && cfg.ready;

  assign q_prod = 30'(p0_v_r) * 30'(RECIP_676);
  assign q_left = (p1_q_r >= 6'(ALPHA)) ? p1_q_r - 6'(ALPHA) : p1_q_r;
  assign q_back = CFG_DATA_W'(p1_q_r) * CFG_DATA_W'(ALPHA * ALPHA);
  assign rem_full = p1_v_r - q_back;
  assign m_prod = 22'(p2_rem_r) * 22'(RECIP_26);
  assign m_back = 10'(p3_mid_r) * 10'(ALPHA);
  assign right_full = p3_rem_r - m_back;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= 3'd0;
      rot_r[1] <= 3'd1;
      rot_r[2] <= 3'd2;
      ring_r   <= '0;
      start_r  <= '0;
      p0_vld_r <= 1'b0;
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
    end else begin
      if (wr) begin
        case (cfg.index)
          REG_ROTOR_LEFT:   rot_r[0] <= cfg.data[2:0];
          REG_ROTOR_MIDDLE: rot_r[1] <= cfg.data[2:0];
          REG_ROTOR_RIGHT:  rot_r[2] <= cfg.data[2:0];
          default: ;
        endcase
      end
      p0_vld_r <= wr && (cfg.index == REG_RING || cfg.index == REG_START);
      p1_vld_r <= p0_vld_r;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      if (p3_vld_r) begin
        if (p3_tag_r) begin
          start_r[0] <= p3_left_r;
          start_r[1] <= p3_mid_r;
          start_r[2] <= right_full[4:0];
        end else begin
          ring_r[0] <= p3_left_r;
          ring_r[1] <= p3_mid_r;
          ring_r[2] <= right_full[4:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    p0_tag_r  <= (cfg.index == REG_START);
    p0_v_r    <= cfg.data;
    p1_tag_r  <= p0_tag_r;
    p1_v_r    <= p0_v_r;
    p1_q_r    <= q_prod[RECIP_676_SH +: 6];
    p2_tag_r  <= p1_tag_r;
    p2_left_r <= q_left[4:0];
    p2_rem_r  <= rem_full[9:0];
    p3_tag_r  <= p2_tag_r;
    p3_left_r <= p2_left_r;
    p3_rem_r  <= p2_rem_r;
    p3_mid_r  <= m_prod[RECIP_26_SH +: 5];
  end

  always_comb begin
    conf.rot[0] = clamp_rotor(rot_r[0]);
    conf.rot[1] = clamp_rotor(rot_r[1]);
    conf.rot[2] = clamp_rotor(rot_r[2]);
    conf.ring   = ring_r;
    conf.start  = start_r;
    conf.busy   = p0_vld_r || p1_vld_r || p2_vld_r || p3_vld_r;
  end

endmodule

### sv/em3_front.sv
module em3_front import em3_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  em3_in_if.sink   in_ch,
  input  em3_cfg_t conf,
  output logic     push_valid,
  input  logic     push_ready,
  output em3_job_t push_job
);

  em3_triple_t pos_r;
  em3_triple_t pos_nxt;
  em3_triple_t base;
  em3_triple_t stepped;
  logic        bad;
  logic        step_left;
  logic        step_mid;
  logic        take;

  assign in_ch.ready = push_ready && !conf.busy;
  assign push_valid  = in_ch.valid && !conf.busy;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    base       = in_ch.message_start ? conf.start : pos_r;
    bad        = in_ch.letter_in > LAST_LETTER;
    step_left  = base[1] == NOTCH[conf.rot[1]];
    step_mid   = (base[2] == NOTCH[conf.rot[2]]) || step_left;
    stepped[2] = add_mod(base[2], 5'd1);
    stepped[1] = step_mid ? add_mod(base[1], 5'd1) : base[1];
    stepped[0] = step_left ? add_mod(base[0], 5'd1) : base[0];
    pos_nxt    = bad ? base : stepped;

    push_job.letter = in_ch.letter_in;
    push_job.bad    = bad;
    push_job.rot    = conf.rot;
    for (int i = 0; i < 3; i++) begin
      push_job.shift[i] = sub_mod(stepped[i], conf.ring[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (take) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

### sv/em3_fifo.sv
module em3_fifo import em3_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  em3_job_t push_job,
  output logic     pop_valid,
  input  logic     pop_ready,
  output em3_job_t pop_job
);

  em3_job_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = cnt_r != QCNT_W'(QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### sv/em3_back.sv
module em3_back import em3_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     pop_valid,
  output logic     pop_ready,
  input  em3_job_t pop_job,
  em3_out_if.source out_ch
);

  logic        vld_r [NSTAGE];
  em3_job_t    job_r [NSTAGE];
  em3_letter_t val_r [NSTAGE];

  logic        src_vld [NSTAGE];
  em3_job_t    src_job [NSTAGE];
  em3_letter_t src_val [NSTAGE];
  em3_letter_t new_val [NSTAGE];
  logic        advance;

  function automatic em3_letter_t rotor_fwd(em3_sel_t rot, em3_letter_t s, em3_letter_t v);
    return sub_mod(wire_fwd(rot, add_mod(v, s)), s);
  endfunction

  function automatic em3_letter_t rotor_back(em3_sel_t rot, em3_letter_t s, em3_letter_t v);
    return sub_mod(wire_back(rot, add_mod(v, s)), s);
  endfunction

  function automatic em3_letter_t pass(int k, em3_job_t j, em3_letter_t v);
    em3_letter_t r;
    case (k)
      0:       r = rotor_fwd(j.rot[2], j.shift[2], v);
      1:       r = rotor_fwd(j.rot[1], j.shift[1], v);
      2:       r = rotor_fwd(j.rot[0], j.shift[0], v);
      3:       r = reflect(v);
      4:       r = rotor_back(j.rot[0], j.shift[0], v);
      5:       r = rotor_back(j.rot[1], j.shift[1], v);
      6:       r = rotor_back(j.rot[2], j.shift[2], v);
      default: r = v;
    endcase
    return r;
  endfunction

  assign advance   = !vld_r[NSTAGE-1] || out_ch.ready;
  assign pop_ready = advance;

  always_comb begin
    src_vld[0] = pop_valid;
    src_job[0] = pop_job;
    src_val[0] = pop_job.letter;
    for (int k = 1; k < NSTAGE; k++) begin
      src_vld[k] = vld_r[k-1];
      src_job[k] = job_r[k-1];
      src_val[k] = val_r[k-1];
    end
    for (int k = 0; k < NSTAGE; k++) begin
      new_val[k] = pass(k, src_job[k], src_val[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTAGE; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (advance) begin
      for (int k = 0; k < NSTAGE; k++) begin
        vld_r[k] <= src_vld[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < NSTAGE; k++) begin
        job_r[k] <= src_job[k];
        val_r[k] <= new_val[k];
      end
    end
  end

  assign out_ch.valid      = vld_r[NSTAGE-1];
  assign out_ch.bad_letter = job_r[NSTAGE-1].bad;
  assign out_ch.letter_out = job_r[NSTAGE-1].bad ? job_r[NSTAGE-1].letter : val_r[NSTAGE-1];

endmodule

### sv/enigma_m3_cipher.sv
// Enigma M3 letter cipher with reflector B and no plugboard. One letter word is taken per clock
// while the queue has room and no ring or start write is unpacking, and one result word leaves
// per clock when the output is not stalled; each result passes a two-entry queue and then the
// seven-pass rotor and reflector pipeline. The front steps the rotor positions as each letter
// is taken, so a new letter may follow in the very next cycle. A write to ring_settings or
// start_positions is split into digits by a four-stage unpacker, and in_ready stays low while
// the unpacker holds it. Rotor selectors above four pick rotor V; letters above Z are echoed
// with bad_letter set and do not step the rotors, although message_start still reloads them.
module enigma_m3_cipher import em3_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  em3_in_if.sink     in_chan,
  em3_out_if.source  out_chan,
  em3_cfg_if.sink    cfg_chan
);

  em3_cfg_t conf;
  logic     push_valid;
  logic     push_ready;
  em3_job_t push_job;
  logic     pop_valid;
  logic     pop_ready;
  em3_job_t pop_job;

  em3_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_chan),
    .conf  (conf)
  );

  em3_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_chan),
    .conf       (conf),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  em3_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  em3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_ch    (out_chan)
  );

`ifndef NO_ASSERTIONS
  a_bad_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.bad_letter |-> out_chan.letter_out > LAST_LETTER)
    else $error("flagged word carries a valid letter");

  a_good_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.bad_letter |-> out_chan.letter_out <= LAST_LETTER)
    else $error("enciphered letter out of range");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |-> !conf.busy)
    else $error("letter taken while settings unpack");

  a_reset_quiet: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_chan.valid)
    else $error("result word right after reset");
`endif

endmodule
